@@ rtl/pvad_pkg.sv @@
// shared types and constants for the peak voice activity detector
package pvad_pkg;

    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned THR_W     = 7;
    localparam int unsigned HANG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // level products: |2*peak-255|*100 and threshold*255 both fit in 15 bits
    localparam int unsigned LEVEL_W   = 15;

    localparam logic [THR_W-1:0]     THR_RESET   = THR_W'(40);
    localparam logic [HANG_W-1:0]    HANG_RESET  = HANG_W'(2000);
    localparam logic [SAMPLE_W-1:0]  FULL_SCALE  = SAMPLE_W'(255);
    localparam logic [6:0]           PCT_SCALE   = 7'd100;

    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HANG      = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic                frame_end;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] frame_peak;
        logic                speech;
        logic                recording;
        logic                started;
        logic                stopped;
    } t_result;

endpackage

@@ rtl/pvad_in_stage.sv @@
// input register stage: holds one accepted item until the core consumes it
module pvad_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pvad_pkg::t_in_item i_item,
    input  logic               i_advance,
    output logic               o_stall,
    output logic               o_valid,
    output pvad_pkg::t_in_item o_item
);

    logic               r_valid;
    pvad_pkg::t_in_item r_item;
    logic               accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/pvad_core.sv @@
// detector state, configuration registers and per-item decision logic
module pvad_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [pvad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pvad_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    input  pvad_pkg::t_in_item                i_item,
    input  logic                              i_out_free,
    output logic                              o_advance,
    output logic                              o_res_valid,
    output pvad_pkg::t_result                 o_result
);

    logic [pvad_pkg::THR_W-1:0]    r_threshold;
    logic [pvad_pkg::HANG_W-1:0]   r_hang_ticks;
    logic [pvad_pkg::SAMPLE_W-1:0] r_peak,      n_peak;
    logic                          r_speech,    n_speech;
    logic                          r_recording, n_recording;
    logic                          r_hang_run,  n_hang_run;
    logic [pvad_pkg::HANG_W-1:0]   r_hang_cnt,  n_hang_cnt;

    logic [pvad_pkg::SAMPLE_W-1:0] peak_new;
    logic [pvad_pkg::SAMPLE_W:0]   twice;
    logic [pvad_pkg::SAMPLE_W-1:0] dev;
    logic [pvad_pkg::LEVEL_W-1:0]  level;
    logic [pvad_pkg::LEVEL_W-1:0]  limit;
    logic                          now_speech;
    logic [pvad_pkg::HANG_W:0]     cnt_next;
    logic                          expired;
    logic                          produces;
    logic                          started;

    // config writes must arrive only while idle; the core itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= pvad_pkg::THR_RESET;
            r_hang_ticks <= pvad_pkg::HANG_RESET;
        end else if (i_cfg_valid) begin
            case (pvad_pkg::t_cfg_idx'(i_cfg_index))
                pvad_pkg::CFG_THRESHOLD: r_threshold  <= i_cfg_data[pvad_pkg::THR_W-1:0];
                pvad_pkg::CFG_HANG:      r_hang_ticks <= i_cfg_data[pvad_pkg::HANG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        peak_new = (i_item.sample > r_peak) ? i_item.sample : r_peak;
        twice    = {peak_new, 1'b0};
        if (twice >= {1'b0, pvad_pkg::FULL_SCALE}) begin
            dev = pvad_pkg::SAMPLE_W'(twice - {1'b0, pvad_pkg::FULL_SCALE});
        end else begin
            dev = pvad_pkg::SAMPLE_W'({1'b0, pvad_pkg::FULL_SCALE} - twice);
        end
        level      = pvad_pkg::LEVEL_W'(dev * pvad_pkg::PCT_SCALE);
        limit      = pvad_pkg::LEVEL_W'(r_threshold * pvad_pkg::FULL_SCALE);
        now_speech = (level >= limit);

        cnt_next = {1'b0, r_hang_cnt} + 1'b1;
        expired  = r_hang_run && (cnt_next >= {1'b0, r_hang_ticks});

        if (i_item.cmd == pvad_pkg::CMD_TICK) begin
            produces = expired;
        end else begin
            produces = i_item.frame_end;
        end
        o_advance   = i_valid && (!produces || i_out_free);
        o_res_valid = produces;

        n_peak      = r_peak;
        n_speech    = r_speech;
        n_recording = r_recording;
        n_hang_run  = r_hang_run;
        n_hang_cnt  = r_hang_cnt;
        started     = 1'b0;

        if (i_item.cmd == pvad_pkg::CMD_TICK) begin
            if (r_hang_run) begin
                if (expired) begin
                    n_hang_run  = 1'b0;
                    n_hang_cnt  = '0;
                    n_recording = 1'b0;
                end else begin
                    n_hang_cnt = cnt_next[pvad_pkg::HANG_W-1:0];
                end
            end
        end else if (!i_item.frame_end) begin
            n_peak = peak_new;
        end else begin
            // speech to silence restarts the hangover
            if (!now_speech && r_speech) begin
                n_hang_run = 1'b1;
                n_hang_cnt = '0;
            end
            // silence to speech cancels it and may start recording
            if (now_speech && !r_speech) begin
                n_hang_run = 1'b0;
                n_hang_cnt = '0;
                if (!r_recording) begin
                    n_recording = 1'b1;
                    started     = 1'b1;
                end
            end
            n_speech = now_speech;
            n_peak   = '0;
        end

        if (i_item.cmd == pvad_pkg::CMD_TICK) begin
            o_result.frame_peak = '0;
            o_result.speech     = r_speech;
            o_result.recording  = 1'b0;
            o_result.started    = 1'b0;
            o_result.stopped    = 1'b1;
        end else begin
            o_result.frame_peak = peak_new;
            o_result.speech     = n_speech;
            o_result.recording  = n_recording;
            o_result.started    = started;
            o_result.stopped    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_speech    <= 1'b0;
            r_recording <= 1'b0;
            r_hang_run  <= 1'b0;
            r_hang_cnt  <= '0;
        end else if (o_advance) begin
            r_peak      <= n_peak;
            r_speech    <= n_speech;
            r_recording <= n_recording;
            r_hang_run  <= n_hang_run;
            r_hang_cnt  <= n_hang_cnt;
        end
    end

    // the hangover only runs through silence
    a_hang_in_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hang_run |-> !r_speech)
        else $error("hangover running during speech");

endmodule

@@ rtl/pvad_out_reg.sv @@
// result register feeding the output channel
module pvad_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pvad_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output pvad_pkg::t_result o_result
);

    logic              r_valid;
    pvad_pkg::t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/peak_voice_activity_detector.sv @@
// top level of the peak voice activity detector with hangover timer
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_cmd, i_sample, i_frame_end
//  result    out        o_valid / i_stall         o_frame_peak, o_speech, o_recording,
//                                                 o_started, o_stopped
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle sustained while no result waits on a stalled result register; an item
// is taken into the input register, then passes the decision logic into the result register
// items that give no result (plain samples, idle or counting ticks) retire without
// waiting on the result side; items with a result wait only for the result register
// reset is synchronous, active low, and restores the default threshold and hangover
// config writes are always ready and take effect on the next cycle
module peak_voice_activity_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_cmd,
    input  logic [pvad_pkg::SAMPLE_W-1:0]      i_sample,
    input  logic                               i_frame_end,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [pvad_pkg::SAMPLE_W-1:0]      o_frame_peak,
    output logic                               o_speech,
    output logic                               o_recording,
    output logic                               o_started,
    output logic                               o_stopped,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pvad_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pvad_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    pvad_pkg::t_in_item in_item;
    pvad_pkg::t_in_item stage_item;
    pvad_pkg::t_result  core_result;
    pvad_pkg::t_result  out_result;
    logic               stage_valid;
    logic               advance;
    logic               res_valid;
    logic               out_free;

    // pack the item fields
    assign in_item.cmd       = pvad_pkg::t_cmd'(i_cmd);
    assign in_item.sample    = i_sample;
    assign in_item.frame_end = i_frame_end;

    // config is always taken
    assign o_cfg_ready = 1'b1;

    pvad_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_stall),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // decision logic and detector state
    pvad_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .i_out_free  (out_free),
        .o_advance   (advance),
        .o_res_valid (res_valid),
        .o_result    (core_result)
    );

    // result register, loaded only by items that give a result
    pvad_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && res_valid),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_frame_peak = out_result.frame_peak;
    assign o_speech     = out_result.speech;
    assign o_recording  = out_result.recording;
    assign o_started    = out_result.started;
    assign o_stopped    = out_result.stopped;

    // a start is always a speech frame that turns recording on
    a_start_in_speech: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_started) |-> (o_speech && o_recording && !o_stopped))
        else $error("start result without speech and recording");

    // a timeout result ends recording and carries no peak
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stopped) |-> (!o_recording && o_frame_peak == '0))
        else $error("timeout result with recording or peak");

    // the stage stalls only while holding an item
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> stage_valid)
        else $error("stall with empty input register");

    // a held result is never overwritten: a held result blocks a new result item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !(advance && res_valid))
        else $error("result register overwritten while stalled");

endmodule
